// File: rtl/skt_pkg.sv
// Shared types and constants of the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned POS_W        = 6;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_VIEW   = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One stored record; the key sits in the lowest bits.
  typedef struct packed {
    logic [31:0]             name_hi;
    logic [63:0]             name_mid;
    logic [63:0]             name_lo;
    logic [31:0]             price;
    logic signed [KEY_W-1:0] key;
  } rec_t;

  localparam int unsigned REC_W     = $bits(rec_t);
  localparam int unsigned OUT_DATA_W = ((POS_W + REC_W + 7) / 8) * 8;

  // Outcome of the shared key comparator.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  // One result as handed from the sequencer to the output register.
  typedef struct packed {
    logic             last;
    status_e          status;
    logic [POS_W-1:0] position;
    rec_t             rec;
  } res_t;

endpackage

// File: rtl/skt_ram.sv
// Record store: one write port and one registered read port.
`timescale 1ns / 1ps

module skt_ram #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(CAPACITY)-1:0] waddr_i,
  input  skt_pkg::rec_t               wdata_i,
  input  logic                        re_i,
  input  logic [$clog2(CAPACITY)-1:0] raddr_i,
  output skt_pkg::rec_t               rdata_o
);

  skt_pkg::rec_t mem [CAPACITY];
  skt_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/skt_cmp.sv
// Shared signed key comparator used on every scanned entry.
`timescale 1ns / 1ps

module skt_cmp (
  input  logic signed [skt_pkg::KEY_W-1:0] a_i,
  input  logic signed [skt_pkg::KEY_W-1:0] b_i,
  output skt_pkg::cmp_t                    cmp_o
);

  assign cmp_o.lt = (a_i < b_i);
  assign cmp_o.eq = (a_i == b_i);

endmodule

// File: rtl/skt_seq.sv
// Sequencer: walks the store one entry a cycle per request; a dump can stall.
`timescale 1ns / 1ps

module skt_seq #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  skt_pkg::req_e               in_req_i,
  input  skt_pkg::rec_t               in_rec_i,
  output logic                        re_o,
  output logic [$clog2(CAPACITY)-1:0] raddr_o,
  output logic                        we_o,
  output logic [$clog2(CAPACITY)-1:0] waddr_o,
  output skt_pkg::rec_t               wdata_o,
  input  skt_pkg::rec_t               rdata_i,
  input  logic                        out_free_i,
  output logic                        out_load_o,
  output skt_pkg::res_t               out_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = skt_pkg::POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FWD  = 3'd1;
  localparam logic [2:0] S_BWD  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;
  localparam logic [2:0] S_DOUT = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [IDX_W-1:0]                 ridx_q, ridx_d;
  logic [IDX_W-1:0]                 pos_q, pos_d;
  logic                             iss_q, iss_d;
  logic                             rvld_q, rvld_d;
  logic                             found_q, found_d;
  skt_pkg::req_e                    req_q;
  logic signed [skt_pkg::KEY_W-1:0] key_q;
  skt_pkg::rec_t                    hit_q, hit_d;
  skt_pkg::status_e                 status_q, status_d;
  skt_pkg::cmp_t                    cmp;
  logic                             last_rd;
  logic [CNT_W-1:0]                 pos_p1;
  logic [CNT_W-1:0]                 idx_p1;

  skt_cmp u_cmp (
    .a_i   (rdata_i.key),
    .b_i   (key_q),
    .cmp_o (cmp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign last_rd    = ((CNT_W'(ridx_q) + CNT_W'(1)) == cnt_q);
  assign pos_p1     = CNT_W'(pos_q) + CNT_W'(1);
  assign idx_p1     = CNT_W'(idx_q) + CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    ridx_d     = ridx_q;
    pos_d      = pos_q;
    iss_d      = iss_q;
    rvld_d     = rvld_q;
    found_d    = found_q;
    hit_d      = hit_q;
    status_d   = status_q;
    re_o       = 1'b0;
    raddr_o    = idx_q;
    we_o       = 1'b0;
    waddr_o    = ridx_q;
    wdata_o    = rdata_i;
    out_load_o = 1'b0;
    out_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          hit_d   = in_rec_i;
          found_d = 1'b0;
          rvld_d  = 1'b0;
          iss_d   = 1'b0;
          if (in_req_i == skt_pkg::REQ_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = skt_pkg::ST_FULL;
              state_d  = S_RES;
            end else if (cnt_q == '0) begin
              pos_d   = '0;
              state_d = S_PUT;
            end else begin
              idx_d   = IDX_W'(cnt_q - CNT_W'(1));
              iss_d   = 1'b1;
              state_d = S_BWD;
            end
          end else if (cnt_q == '0) begin
            status_d = skt_pkg::ST_EMPTY;
            state_d  = S_RES;
          end else if (in_req_i == skt_pkg::REQ_DUMP) begin
            re_o    = 1'b1;
            raddr_o = '0;
            idx_d   = '0;
            state_d = S_DOUT;
          end else begin
            idx_d   = '0;
            iss_d   = 1'b1;
            state_d = S_FWD;
          end
        end
      end

      // Forward scan for remove and view. Once the match is seen on a remove,
      // every later entry is written back one place lower; a view stops at the match.
      S_FWD: begin
        if (iss_q) begin
          re_o  = 1'b1;
          idx_d = idx_q + IDX_W'(1);
          iss_d = (idx_p1 != cnt_q);
        end
        rvld_d = iss_q;
        ridx_d = idx_q;
        if (rvld_q) begin
          if (found_q) begin
            we_o    = (req_q == skt_pkg::REQ_REMOVE);
            waddr_o = ridx_q - IDX_W'(1);
          end else if (cmp.eq) begin
            found_d = 1'b1;
            pos_d   = ridx_q;
            hit_d   = rdata_i;
          end
          if (last_rd || (found_d && req_q == skt_pkg::REQ_VIEW)) begin
            iss_d    = 1'b0;
            rvld_d   = 1'b0;
            status_d = found_d ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
            if (found_d && req_q == skt_pkg::REQ_REMOVE) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
            state_d = S_RES;
          end
        end
      end

      // Backward scan for insert: entries not below the new key move up
      // by one until a smaller key or the head of the table is reached.
      S_BWD: begin
        if (iss_q) begin
          re_o  = 1'b1;
          idx_d = idx_q - IDX_W'(1);
          iss_d = (idx_q != '0);
        end
        rvld_d = iss_q;
        ridx_d = idx_q;
        if (rvld_q) begin
          if (!cmp.lt) begin
            we_o    = 1'b1;
            waddr_o = ridx_q + IDX_W'(1);
            if (ridx_q == '0) begin
              pos_d   = '0;
              iss_d   = 1'b0;
              rvld_d  = 1'b0;
              state_d = S_PUT;
            end
          end else begin
            pos_d   = ridx_q + IDX_W'(1);
            iss_d   = 1'b0;
            rvld_d  = 1'b0;
            state_d = S_PUT;
          end
        end
      end

      S_PUT: begin
        we_o     = 1'b1;
        waddr_o  = pos_q;
        wdata_o  = hit_q;
        cnt_d    = cnt_q + CNT_W'(1);
        status_d = skt_pkg::ST_OK;
        state_d  = S_RES;
      end

      S_RES: begin
        if (out_free_i) begin
          out_load_o    = 1'b1;
          out_o.last    = 1'b1;
          out_o.status  = status_q;
          if (status_q == skt_pkg::ST_OK) begin
            out_o.position = POS_W'(pos_p1);
            out_o.rec      = hit_q;
          end
          state_d = S_IDLE;
        end
      end

      // Dump: the read data for idx_q is waiting; the next read goes out
      // in the same cycle as the beat is loaded.
      S_DOUT: begin
        if (out_free_i) begin
          out_load_o     = 1'b1;
          out_o.last     = (idx_p1 == cnt_q);
          out_o.status   = skt_pkg::ST_OK;
          out_o.position = POS_W'(idx_p1);
          out_o.rec      = rdata_i;
          if (idx_p1 == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            re_o    = 1'b1;
            raddr_o = idx_q + IDX_W'(1);
            idx_d   = idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      iss_q   <= 1'b0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ridx_q   <= ridx_d;
    pos_q    <= pos_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
      key_q <= in_rec_i.key;
    end
  end

endmodule

// File: rtl/sorted_key_table_top.sv
// Top level of the sorted key table: stream ports, record store, output register.
//
// The slave channel takes one request per beat: tuser carries the request type
// (insert, remove, view, dump) and tdata the key, price pattern and 20-byte name.
// The master channel returns result beats: tuser is the status, tdata holds the
// position and the record, and tlast marks the final beat of a request.
// Records are kept in ascending key order in a single-port-write, registered-read
// memory; one comparator inspects one entry per cycle under a small sequencer.
// With the receiver ready, the time from one accepted request to the next grows
// with the entries scanned: an insert scans back from the tail to its landing
// place, a remove scans every record, a view stops at its hit (every record on a
// miss), a dump reads every record and a full or empty report scans none; the
// memory read port, one entry per cycle, sets this pace.
// s_axis_tready is high only while the sequencer is idle, so one request is in
// work at a time; a finished result may wait in the output register while the
// next request is taken in.
// When the receiver holds m_axis_tready low, the result beat holds and the
// sequencer waits; a dump resumes where it stopped.
// Reset empties the table at once; memory contents are not cleared, as entries
// beyond the record count are never read.
`timescale 1ns / 1ps

module sorted_key_table_top #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key, price_bits, name_word0, name_word1, name_word2 (lowest first)
  input  logic [skt_pkg::REC_W-1:0]       s_axis_tdata,
  // req_type
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // position, rec_key, rec_price_bits, rec_name_word0..2, zero pad (lowest first)
  output logic [skt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PAD_W = skt_pkg::OUT_DATA_W - skt_pkg::REC_W - skt_pkg::POS_W;

  logic             re, we;
  logic [IDX_W-1:0] raddr, waddr;
  skt_pkg::rec_t    wdata, rdata;
  logic             out_load, out_free;
  skt_pkg::res_t    res;
  logic             out_vld_q;
  skt_pkg::res_t    out_q;

  skt_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  skt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (skt_pkg::req_e'(s_axis_tuser)),
    .in_rec_i   (skt_pkg::rec_t'(s_axis_tdata)),
    .re_o       (re),
    .raddr_o    (raddr),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .out_o      (res)
  );

  // The output register is free when empty or when its beat leaves now.
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q.rec, out_q.position};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

// File: dv/sorted_key_table_top_test.sv
// Self-checking stream testbench for the sorted key table top level.
`timescale 1ns / 1ps

module sorted_key_table_top_test;

  localparam int unsigned     CAP            = skt_pkg::CAPACITY_DEF;
  localparam int unsigned     POS_W          = skt_pkg::POS_W;
  localparam int unsigned     REC_W          = skt_pkg::REC_W;
  localparam int unsigned     OUT_DATA_W     = skt_pkg::OUT_DATA_W;
  localparam int unsigned     LONG_HOLD      = 200;
  localparam int unsigned     SETTLE         = 2 * CAP + 10;
  localparam int unsigned     RAND_PER_PHASE = 135;
  localparam int unsigned     N_DIRECTED     = 17;
  localparam longint unsigned CYCLE_LIMIT    = 1_000_000;

  // Price and name bits of a directed beat: {name_hi, name_mid, name_lo, price}.
  localparam logic [191:0] PAY_ZERO = '0;
  localparam logic [191:0] PAY_ONES = '1;
  localparam logic [191:0] PAY_A    = {6{32'h5a3c_96e1}};
  localparam logic [191:0] PAY_B    = {6{32'ha5c3_691e}};

  typedef struct {
    skt_pkg::req_e      req;
    logic signed [31:0] key;
    logic [191:0]       payload;
    bit                 has_exp;
    skt_pkg::status_e   exp_status;
    logic [POS_W-1:0]   exp_pos;
  } directed_row_t;

  // Expected status and position are typed in only where they are obvious.
  directed_row_t directed_rows[N_DIRECTED] = '{
    '{skt_pkg::REQ_VIEW,   32'sd0,         PAY_ZERO, 1'b1, skt_pkg::ST_EMPTY,     6'd0},
    '{skt_pkg::REQ_REMOVE, 32'sd0,         PAY_ZERO, 1'b1, skt_pkg::ST_EMPTY,     6'd0},
    '{skt_pkg::REQ_DUMP,   32'sd0,         PAY_ZERO, 1'b1, skt_pkg::ST_EMPTY,     6'd0},
    '{skt_pkg::REQ_INSERT, 32'sh7fff_ffff, PAY_ONES, 1'b1, skt_pkg::ST_OK,        6'd1},
    '{skt_pkg::REQ_INSERT, 32'sh8000_0000, PAY_ZERO, 1'b1, skt_pkg::ST_OK,        6'd1},
    '{skt_pkg::REQ_INSERT, 32'sd0,         PAY_A,    1'b1, skt_pkg::ST_OK,        6'd2},
    '{skt_pkg::REQ_INSERT, 32'sd0,         PAY_B,    1'b1, skt_pkg::ST_OK,        6'd2},
    '{skt_pkg::REQ_INSERT, -32'sd1,        PAY_A,    1'b1, skt_pkg::ST_OK,        6'd2},
    '{skt_pkg::REQ_VIEW,   32'sd0,         PAY_ZERO, 1'b0, skt_pkg::ST_OK,        6'd0},
    '{skt_pkg::REQ_VIEW,   32'sd5,         PAY_ONES, 1'b1, skt_pkg::ST_NOT_FOUND, 6'd0},
    '{skt_pkg::REQ_REMOVE, 32'sd5,         PAY_ZERO, 1'b1, skt_pkg::ST_NOT_FOUND, 6'd0},
    '{skt_pkg::REQ_DUMP,   32'sd0,         PAY_ZERO, 1'b0, skt_pkg::ST_OK,        6'd0},
    '{skt_pkg::REQ_REMOVE, 32'sd0,         PAY_ZERO, 1'b0, skt_pkg::ST_OK,        6'd0},
    '{skt_pkg::REQ_REMOVE, 32'sh8000_0000, PAY_ONES, 1'b1, skt_pkg::ST_OK,        6'd1},
    '{skt_pkg::REQ_VIEW,   32'sh7fff_ffff, PAY_ZERO, 1'b0, skt_pkg::ST_OK,        6'd0},
    '{skt_pkg::REQ_INSERT, 32'sd1,         PAY_B,    1'b0, skt_pkg::ST_OK,        6'd0},
    '{skt_pkg::REQ_DUMP,   32'sd0,         PAY_ZERO, 1'b0, skt_pkg::ST_OK,        6'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [REC_W-1:0]      s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  skt_pkg::rec_t   shadow_recs[$];
  skt_pkg::res_t   pending_results[$];
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  bit              rx_hold_req;
  int unsigned     n_errors;
  int unsigned     n_beats;
  int unsigned     n_full;
  int unsigned     peak_fill;
  int unsigned     req_count[4];
  longint unsigned cycle_count;

  sorted_key_table_top #(
    .CAPACITY (CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_key_table_top verification failed");
      $finish;
    end
  end

  function automatic skt_pkg::res_t empty_report(skt_pkg::status_e st);
    skt_pkg::res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic skt_pkg::res_t record_report(int unsigned idx, logic is_last);
    skt_pkg::res_t r;
    r.status   = skt_pkg::ST_OK;
    r.position = POS_W'(idx + 1);
    r.rec      = shadow_recs[idx];
    r.last     = is_last;
    return r;
  endfunction

  // Queues the result beats of one request, updates the shadow table and
  // hands back the first of the new beats.
  function automatic skt_pkg::res_t apply_request(skt_pkg::req_e req, skt_pkg::rec_t d);
    int unsigned pos;
    int unsigned first_idx;
    pos       = 0;
    first_idx = pending_results.size();
    if (req == skt_pkg::REQ_INSERT) begin
      if (shadow_recs.size() >= CAP) begin
        pending_results.push_back(empty_report(skt_pkg::ST_FULL));
        n_full++;
      end else begin
        while (pos < shadow_recs.size() && $signed(shadow_recs[pos].key) < $signed(d.key))
          pos++;
        shadow_recs.insert(pos, d);
        pending_results.push_back(record_report(pos, 1'b1));
        if (shadow_recs.size() > peak_fill) peak_fill = shadow_recs.size();
      end
    end else if (shadow_recs.size() == 0) begin
      pending_results.push_back(empty_report(skt_pkg::ST_EMPTY));
    end else if (req == skt_pkg::REQ_DUMP) begin
      for (int unsigned i = 0; i < shadow_recs.size(); i++)
        pending_results.push_back(record_report(i, i + 1 == shadow_recs.size()));
    end else begin
      while (pos < shadow_recs.size() && shadow_recs[pos].key != d.key)
        pos++;
      if (pos == shadow_recs.size()) begin
        pending_results.push_back(empty_report(skt_pkg::ST_NOT_FOUND));
      end else begin
        pending_results.push_back(record_report(pos, 1'b1));
        if (req == skt_pkg::REQ_REMOVE) shadow_recs.delete(pos);
      end
    end
    return pending_results[first_idx];
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  function automatic void compare_result(skt_pkg::res_t want, skt_pkg::res_t got);
    check_field("status", want.status, got.status);
    check_field("position", want.position, got.position);
    check_field("rec_key", want.rec.key, got.rec.key);
    check_field("rec_price_bits", want.rec.price, got.rec.price);
    check_field("rec_name_word0", want.rec.name_lo, got.rec.name_lo);
    check_field("rec_name_word1", want.rec.name_mid, got.rec.name_mid);
    check_field("rec_name_word2", want.rec.name_hi, got.rec.name_hi);
    check_field("last", want.last, got.last);
  endfunction

  function automatic skt_pkg::rec_t random_record(logic signed [31:0] k);
    skt_pkg::rec_t d;
    d.key      = k;
    d.price    = $urandom;
    d.name_lo  = {$urandom, $urandom};
    d.name_mid = {$urandom, $urandom};
    d.name_hi  = $urandom;
    return d;
  endfunction

  // Mostly keys that collide or are already held, so lookups hit and
  // equal keys pile up; now and then the extremes or a wide random value.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(9))
      0:          return 32'sh8000_0000;
      1:          return 32'sh7fff_ffff;
      2, 3, 4, 5: return int'($urandom_range(8)) - 4;
      6, 7, 8: begin
        if (shadow_recs.size() > 0) return shadow_recs[$urandom_range(shadow_recs.size() - 1)].key;
        else return int'($urandom_range(8)) - 4;
      end
      default:    return $urandom;
    endcase
  endfunction

  // Offers one beat until it is taken; the valid stays high unless a gap follows.
  task automatic send_request(input skt_pkg::req_e req, input skt_pkg::rec_t d,
                              output skt_pkg::res_t first);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    first = apply_request(req, d);
    req_count[req]++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic random_request();
    int unsigned   roll;
    int unsigned   ins_pct;
    skt_pkg::req_e req;
    skt_pkg::res_t first;
    roll    = $urandom_range(99);
    ins_pct = (shadow_recs.size() + 4 < CAP) ? 45 : 20;
    if (roll < ins_pct) req = skt_pkg::REQ_INSERT;
    else if (roll < ins_pct + 30) req = skt_pkg::REQ_REMOVE;
    else if (roll < ins_pct + 47) req = skt_pkg::REQ_VIEW;
    else req = skt_pkg::REQ_DUMP;
    send_request(req, random_record(pick_key()), first);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver: random back-pressure, or one long hold-off when asked.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    skt_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.position = m_axis_tdata[POS_W-1:0];
      got.rec      = m_axis_tdata[POS_W +: REC_W];
      got.status   = skt_pkg::status_e'(m_axis_tuser);
      got.last     = m_axis_tlast;
      n_beats++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: tuser %h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
    end
  end

  initial begin
    skt_pkg::res_t first;
    skt_pkg::rec_t d;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= skt_pkg::REQ_INSERT;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      d = skt_pkg::rec_t'({directed_rows[i].payload, directed_rows[i].key});
      send_request(directed_rows[i].req, d, first);
      if (directed_rows[i].has_exp) begin
        check_field($sformatf("row %0d status", i), directed_rows[i].exp_status, first.status);
        check_field($sformatf("row %0d position", i), directed_rows[i].exp_pos, first.position);
      end
    end
    wait_results_drained();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 65 : 0;
      rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 21 : 0;

      // Fill to capacity, knock on the full table, dump every record and view one key.
      if (phase == 1) begin
        while (shadow_recs.size() < CAP)
          send_request(skt_pkg::REQ_INSERT, random_record(pick_key()), first);
        send_request(skt_pkg::REQ_INSERT, random_record(pick_key()), first);
        send_request(skt_pkg::REQ_INSERT, random_record(32'sh7fff_ffff), first);
        send_request(skt_pkg::REQ_DUMP, random_record(pick_key()), first);
        send_request(skt_pkg::REQ_VIEW, random_record(pick_key()), first);
      end

      for (int unsigned n = 0; n < RAND_PER_PHASE; n++) begin
        // The sender carries on while the receiver holds off, so the block backs up.
        if (phase == 0 && n == 40) rx_hold_req = 1'b1;
        random_request();
      end

      // Empty the table again, then send a view, a remove and a dump to the empty table.
      if (phase == 2) begin
        while (shadow_recs.size() > 0)
          send_request(skt_pkg::REQ_REMOVE, random_record(shadow_recs[0].key), first);
        send_request(skt_pkg::REQ_VIEW, random_record(pick_key()), first);
        send_request(skt_pkg::REQ_REMOVE, random_record(pick_key()), first);
        send_request(skt_pkg::REQ_DUMP, random_record(pick_key()), first);
      end
      wait_results_drained();
    end

    repeat (SETTLE) @(posedge clk_i);
    $display("Requests sent: %0d inserts, %0d removes, %0d views, %0d dumps; %0d beats checked.",
             req_count[skt_pkg::REQ_INSERT], req_count[skt_pkg::REQ_REMOVE],
             req_count[skt_pkg::REQ_VIEW], req_count[skt_pkg::REQ_DUMP], n_beats);
    $display("Table peaked at %0d of %0d records with %0d inserts refused as full.",
             peak_fill, CAP, n_full);
    if (n_errors == 0) begin
      $display("sorted_key_table_top verification clean");
    end else begin
      $display("sorted_key_table_top verification failed");
    end
    $finish;
  end

endmodule
